### hdl/md5bc_pkg.sv
// ----------------------------------------------------------------------------
// MD5 block compress package
// Shared types, initial value and per-step constants for the MD5 compression
// pipeline.
// ----------------------------------------------------------------------------
package md5bc_pkg;

   // Number of MD5 steps, one pipeline stage each.
   localparam int unsigned NumSteps = 64;

   // Fixed MD5 initial value.
   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   // Input item: sixteen message words, two per field, lower word in the low half.
   typedef struct packed {
      logic [63:0] words_0_1;
      logic [63:0] words_2_3;
      logic [63:0] words_4_5;
      logic [63:0] words_6_7;
      logic [63:0] words_8_9;
      logic [63:0] words_10_11;
      logic [63:0] words_12_13;
      logic [63:0] words_14_15;
   } req_type;

   // Result item: the four digest words after feed-forward.
   typedef struct packed {
      logic [31:0] digest_a;
      logic [31:0] digest_b;
      logic [31:0] digest_c;
      logic [31:0] digest_d;
   } rsp_type;

   // Data carried between pipeline stages: working state plus the message.
   typedef struct packed {
      logic [31:0]        a;
      logic [31:0]        b;
      logic [31:0]        c;
      logic [31:0]        d;
      logic [15:0][31:0]  msg;
   } pipe_type;

   // Additive constant of one step.
   function automatic logic [31:0] step_const(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   // Left-rotate amount of one step, chosen by round and step position.
   function automatic logic [4:0] rot_amount(input logic [5:0] idx);
      logic [4:0] s;
      case ({idx[5:4], idx[1:0]})
         4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
         4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // Message word used by one step.
   function automatic logic [3:0] msg_index(input logic [5:0] idx);
      logic [7:0] wide;
      logic [3:0] w;
      wide = {2'b00, idx};
      case (idx[5:4])
         2'd0:    w = idx[3:0];
         2'd1:    w = 4'((wide * 8'd5) + 8'd1);
         2'd2:    w = 4'((wide * 8'd3) + 8'd5);
         default: w = 4'(wide * 8'd7);
      endcase
      return w;
   endfunction

endpackage

### hdl/md5_block_compress_unit.sv
// ----------------------------------------------------------------------------
// MD5 block compress unit
// Computes the MD5 compression of one padded 512-bit block from the fixed
// initial value, with feed-forward, as a 64-stage pipeline.
// ----------------------------------------------------------------------------
//  Channel   Ports                                Direction  Contents
//  request   req_valid, req_stall, req_payload    in         sixteen message words
//  response  rsp_valid, rsp_stall, rsp_payload    out        four digest words
//
//  One block is accepted per cycle while req_stall is low; each block passes
//  the 64 step stages and then the result buffer before its result is shown.
//  Reset clears all stage valid bits and the result buffer.
//  A two-entry result buffer absorbs stalls; req_stall rises only when both
//  entries are full, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
module md5_block_compress_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  md5bc_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output md5bc_pkg::rsp_type  rsp_payload
);

   localparam int unsigned Steps = md5bc_pkg::NumSteps;

   logic                 en;
   logic [Steps:0]       stage_valid;
   md5bc_pkg::pipe_type  stage_data [Steps+1];
   logic [7:0][63:0]     fields;

   // Unpack the request into the initial working state.
   assign fields = {req_payload.words_14_15, req_payload.words_12_13,
                    req_payload.words_10_11, req_payload.words_8_9,
                    req_payload.words_6_7,   req_payload.words_4_5,
                    req_payload.words_2_3,   req_payload.words_0_1};

   always_comb begin
      stage_data[0].a = md5bc_pkg::IV_A;
      stage_data[0].b = md5bc_pkg::IV_B;
      stage_data[0].c = md5bc_pkg::IV_C;
      stage_data[0].d = md5bc_pkg::IV_D;
      for (int i = 0; i < 8; i++) begin
         stage_data[0].msg[2*i]     = fields[i][31:0];
         stage_data[0].msg[2*i + 1] = fields[i][63:32];
      end
   end

   assign stage_valid[0] = req_valid;
   assign req_stall      = !en;

   // Step pipeline, one MD5 step per stage.
   for (genvar s = 0; s < Steps; s++) begin : g_step
      md5bc_step #(
         .StepIndex (s)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stage_valid[s]),
         .in_data   (stage_data[s]),
         .out_valid (stage_valid[s+1]),
         .out_data  (stage_data[s+1])
      );
   end

   // Feed-forward and result buffer.
   md5bc_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (stage_valid[Steps]),
      .push_data   (stage_data[Steps]),
      .en          (en),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### hdl/md5bc_step.sv
// ----------------------------------------------------------------------------
// MD5 step stage
// One registered MD5 step: round function, four-way add, rotate and add.
// ----------------------------------------------------------------------------
module md5bc_step #(
   parameter int unsigned StepIndex = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  md5bc_pkg::pipe_type  in_data,
   output logic                 out_valid,
   output md5bc_pkg::pipe_type  out_data
);

   localparam logic [5:0]  Idx   = 6'(StepIndex);
   localparam logic [31:0] Kval  = md5bc_pkg::step_const(Idx);
   localparam int unsigned Shift = int'(md5bc_pkg::rot_amount(Idx));
   localparam logic [3:0]  Widx  = md5bc_pkg::msg_index(Idx);
   localparam logic [1:0]  Round = Idx[5:4];

   logic                 valid_ff;
   md5bc_pkg::pipe_type  data_ff;
   md5bc_pkg::pipe_type  data_in;
   logic [31:0]          fv;
   logic [31:0]          sum;
   logic [31:0]          rot;

   // Round function for this step's round.
   always_comb begin
      case (Round)
         2'd0:    fv = in_data.d ^ (in_data.b & (in_data.c ^ in_data.d));
         2'd1:    fv = in_data.c ^ (in_data.d & (in_data.b ^ in_data.c));
         2'd2:    fv = in_data.b ^ in_data.c ^ in_data.d;
         default: fv = in_data.c ^ (in_data.b | ~in_data.d);
      endcase
   end

   // Step sum, rotate, and the shift of the working words.
   always_comb begin
      sum          = in_data.a + fv + in_data.msg[Widx] + Kval;
      rot          = (sum << Shift) | (sum >> (32 - Shift));
      data_in      = in_data;
      data_in.a    = in_data.d;
      data_in.d    = in_data.c;
      data_in.c    = in_data.b;
      data_in.b    = in_data.b + rot;
   end

   // Stage register; the whole pipeline holds while en is low.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hdl/md5bc_outbuf.sv
// ----------------------------------------------------------------------------
// MD5 output buffer
// Feed-forward addition and a two-entry result buffer that decouples the
// result stall from the pipeline advance.
// ----------------------------------------------------------------------------
module md5bc_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  md5bc_pkg::pipe_type  push_data,
   output logic                 en,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output md5bc_pkg::rsp_type   rsp_payload
);

   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   md5bc_pkg::rsp_type  head_ff;
   md5bc_pkg::rsp_type  tail_ff;
   md5bc_pkg::rsp_type  result;
   logic                push;
   logic                pop;

   // The pipeline moves whenever a slot is free; at most one push per cycle.
   assign en   = (count_ff != 2'd2);
   assign push = en && push_valid;
   assign pop  = (count_ff != 2'd0) && !rsp_stall;

   // Feed-forward of the initial value.
   always_comb begin
      result.digest_a = push_data.a + md5bc_pkg::IV_A;
      result.digest_b = push_data.b + md5bc_pkg::IV_B;
      result.digest_c = push_data.c + md5bc_pkg::IV_C;
      result.digest_d = push_data.d + md5bc_pkg::IV_D;
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Buffer occupancy and entries; head is what the result port shows.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      if (pop) begin
         if (count_ff == 2'd2) begin
            head_ff <= tail_ff;
            if (push) begin
               tail_ff <= result;
            end
         end else if (push) begin
            head_ff <= result;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_ff <= result;
         end else begin
            tail_ff <= result;
         end
      end
   end

   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = head_ff;

endmodule

### hdl/md5bc_checker.sv
// ----------------------------------------------------------------------------
// MD5 block compress checker
// Port-level assertions on the compress unit, attached with a bind.
// ----------------------------------------------------------------------------
module md5bc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input md5bc_pkg::req_type  req_payload,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input md5bc_pkg::rsp_type  rsp_payload
);

   // A stalled result stays shown and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // The unit pushes back on requests only while results are backed up.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result pending");

   // Backpressure on requests only follows a stalled result transfer.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_stall))
      else $error("request stalled without a result stall");

   // Nothing is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("unit not empty after reset");

endmodule

bind md5_block_compress_unit md5bc_checker u_checker (.*);

### verif/md5_digest_checker.sv
// ----------------------------------------------------------------------------
// MD5 digest checker
// Watches the block and digest channels of the MD5 compression unit. Each
// block transfer is hashed by a behavioral MD5 compression, and the digest is
// queued. Each digest transfer is compared word by word with the oldest
// queued digest.
// ----------------------------------------------------------------------------
module md5_digest_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  md5bc_pkg::req_type req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  md5bc_pkg::rsp_type rsp_payload,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Chaining value that every block starts from.
   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   // Additive constant of each of the 64 steps, step 0 first.
   localparam logic [0:63][31:0] StepAdd = {
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left-rotate amounts, four per round, round 0 first.
   localparam logic [0:15][4:0] StepRot = {
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   md5bc_pkg::rsp_type digest_q[$];
   int                 mismatches = 0;

   // Full MD5 compression of one block from the initial value, with feed-forward.
   function automatic md5bc_pkg::rsp_type md5_compress(input md5bc_pkg::req_type blk);
      logic [15:0][31:0]  w;
      logic [31:0]        a, b, c, d, f, sum, carry;
      int unsigned        g, s;
      md5bc_pkg::rsp_type digest;
      w = {blk.words_14_15, blk.words_12_13, blk.words_10_11, blk.words_8_9,
           blk.words_6_7, blk.words_4_5, blk.words_2_3, blk.words_0_1};
      a = InitA;
      b = InitB;
      c = InitC;
      d = InitD;
      for (int i = 0; i < 64; i++) begin
         // Round function and message word order change every 16 steps.
         case (i / 16)
            0: begin
               f = d ^ (b & (c ^ d));
               g = i % 16;
            end
            1: begin
               f = c ^ (d & (b ^ c));
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         sum   = a + f + w[g] + StepAdd[i];
         s     = StepRot[(i / 16) * 4 + i % 4];
         carry = d;
         d     = c;
         c     = b;
         b     = b + ((sum << s) | (sum >> (32 - s)));
         a     = carry;
      end
      digest.digest_a = a + InitA;
      digest.digest_b = b + InitB;
      digest.digest_c = c + InitC;
      digest.digest_d = d + InitD;
      return digest;
   endfunction

   task automatic check_word(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Retire digest transfers against the queue, then queue new block transfers.
   always @(posedge clock) begin : watch
      md5bc_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected digest, expected none, actual %h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               want = digest_q.pop_front();
               check_word("digest_a", want.digest_a, rsp_payload.digest_a);
               check_word("digest_b", want.digest_b, rsp_payload.digest_b);
               check_word("digest_c", want.digest_c, rsp_payload.digest_c);
               check_word("digest_d", want.digest_d, rsp_payload.digest_d);
            end
         end
         if (req_valid && !req_stall) begin
            digest_q.push_back(md5_compress(req_payload));
         end
      end
      pending_count <= digest_q.size();
      fail_count    <= mismatches;
   end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// MD5 block compress testbench
// Drives directed and random 512-bit blocks into the MD5 compression unit
// under random idling on both channels, with a long digest hold-off and a
// full drain, and leaves prediction and comparison to the digest checker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomBlocks = 530;
   localparam int HoldCycles   = 300;
   localparam int CycleLimit   = 400000;
   localparam int DrainCycles  = 80;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   md5bc_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   md5bc_pkg::rsp_type rsp_payload;

   int      failures;
   int      pending;

   // Idling controls: gap and stall chances in percent per decision point, and a hold-off request count.
   int unsigned gap_pct       = 0;
   int unsigned stall_pct     = 0;
   int unsigned hold_requests = 0;

   md5_block_compress_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   md5_digest_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .fail_count    (failures),
      .pending_count (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top failed");
      $finish;
   end

   // Digest side: random stall bursts, plus one long hold-off on request.
   initial begin : digest_receiver
      int          burst;
      int unsigned holds_done;
      holds_done = 0;
      forever begin
         if (holds_done != hold_requests) begin
            holds_done++;
            repeat (HoldCycles) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else if ($urandom_range(99) < stall_pct) begin
            burst = $urandom_range(12, 1);
            repeat (burst) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Message bytes are little-endian: byte i sits in bits 8i+7:8i.
   function automatic md5bc_pkg::req_type block_from_bytes(input logic [511:0] flat);
      md5bc_pkg::req_type blk;
      blk.words_0_1   = flat[63:0];
      blk.words_2_3   = flat[127:64];
      blk.words_4_5   = flat[191:128];
      blk.words_6_7   = flat[255:192];
      blk.words_8_9   = flat[319:256];
      blk.words_10_11 = flat[383:320];
      blk.words_12_13 = flat[447:384];
      blk.words_14_15 = flat[511:448];
      return blk;
   endfunction

   // A correctly padded single-block message of len random bytes (len <= 55).
   function automatic md5bc_pkg::req_type padded_block(input int len);
      logic [511:0] flat;
      flat = '0;
      for (int i = 0; i < len; i++) begin
         flat[8 * i +: 8] = 8'($urandom);
      end
      flat[8 * len +: 8] = 8'h80;
      flat[448 +: 64]    = 64'(len * 8);
      return block_from_bytes(flat);
   endfunction

   // Mostly uniform blocks, some padded messages, some sparse or dense ones.
   function automatic md5bc_pkg::req_type random_block();
      logic [511:0] flat;
      int unsigned  kind;
      kind = $urandom_range(9);
      if (kind == 6 || kind == 7) begin
         return padded_block($urandom_range(55));
      end
      for (int i = 0; i < 16; i++) begin
         if (kind == 8) begin
            flat[32 * i +: 32] = $urandom & $urandom & $urandom;
         end else if (kind == 9) begin
            flat[32 * i +: 32] = $urandom | $urandom | $urandom;
         end else begin
            flat[32 * i +: 32] = $urandom;
         end
      end
      return block_from_bytes(flat);
   endfunction

   // Offer one block and hold it until the transfer.
   task automatic send_block(input md5bc_pkg::req_type blk);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= blk;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic pause_sender();
      int burst;
      if ($urandom_range(99) < gap_pct) begin
         burst = $urandom_range(12, 1);
         repeat (burst) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      md5bc_pkg::req_type directed_q[$];
      logic [511:0]       flat;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed blocks: extremes, known padded messages, repeated-word and single-field patterns.
      directed_q.push_back(block_from_bytes('0));
      directed_q.push_back(block_from_bytes('1));
      directed_q.push_back(block_from_bytes(512'h80));
      flat              = '0;
      flat[31:0]        = 32'h80636261;
      flat[448 +: 64]   = 64'd24;
      directed_q.push_back(block_from_bytes(flat));
      directed_q.push_back(block_from_bytes({16{32'haaaaaaaa}}));
      directed_q.push_back(block_from_bytes({16{32'h55555555}}));
      directed_q.push_back(block_from_bytes({16{32'h80000000}}));
      directed_q.push_back(block_from_bytes({16{32'h00000001}}));
      for (int k = 0; k < 8; k++) begin
         flat            = '0;
         flat[64 * k +: 64] = '1;
         directed_q.push_back(block_from_bytes(flat));
      end
      directed_q.push_back(padded_block(55));
      directed_q.push_back(padded_block(0));
      foreach (directed_q[i]) begin
         send_block(directed_q[i]);
      end
      wait_drained();

      // Random blocks in phases of different idling.
      for (int n = 0; n < RandomBlocks; n++) begin
         if (n == 0) begin
            // Back-to-back blocks against a long digest hold-off fill the pipeline.
            gap_pct   = 0;
            stall_pct = 0;
            hold_requests++;
         end else if (n == 130) begin
            gap_pct   = 25;
            stall_pct = 25;
         end else if (n == 300) begin
            wait_drained();
            gap_pct   = 0;
            stall_pct = 0;
         end else if (n == 380) begin
            gap_pct   = 10;
            stall_pct = 45;
         end else if (n == 470) begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         pause_sender();
         send_block(random_block());
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

### md5_block_compress_unit.f
hdl/md5bc_pkg.sv
hdl/md5bc_step.sv
hdl/md5bc_outbuf.sv
hdl/md5_block_compress_unit.sv
hdl/md5bc_checker.sv
verif/md5_digest_checker.sv
verif/tb_top.sv
